// ===== hw/rtl/s88fb_pkg.sv =====
// Shared types and constants for the s88 feedback bus reader.
// Holds the input/output word structs, register indexes and bus constants.
// No dependencies.
`timescale 1ns / 1ps

package s88fb_pkg;

    // Bus geometry
    localparam int CONTACTS_PER_MODULE = 16;
    localparam int DEF_MAX_MODULES     = 8;

    // Field and port widths
    localparam int QUERY_W     = 8;
    localparam int UNIT_W      = 16;
    localparam int MODCNT_W    = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULE_COUNT = 1'd1;

    // Register reset values
    localparam logic [UNIT_W-1:0]   UNIT_TICKS_RESET   = 16'd25;
    localparam logic [MODCNT_W-1:0] MODULE_COUNT_RESET = 4'd1;

    // One input word
    typedef struct packed {
        logic               start_req;
        logic               data_pin;
        logic [QUERY_W-1:0] query_index;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic load_line;
        logic clock_line;
        logic reset_line;
        logic busy_res;
        logic done_res;
        logic contact_state;
        logic query_valid;
    } out_word_t;

    // Bus line levels
    typedef struct packed {
        logic load_l;
        logic clock_l;
        logic reset_l;
    } line_set_t;

    // Per-tick status from the sequencer to the store and the result stage
    typedef struct packed {
        logic wr_en;
        logic wr_bit;
        logic busy;
        logic done;
    } seq_ctrl_t;

endpackage

// ===== hw/rtl/s88fb_seq.sv =====
// Pulse sequencer of the s88 feedback bus reader: phase, unit and bit counters, lines.
// Produces next line levels, store write control and the current fill count.
// Depends on s88fb_pkg.
`timescale 1ns / 1ps

module s88fb_seq
    import s88fb_pkg::*;
#(
    parameter int MAX_MODULES = DEF_MAX_MODULES,
    parameter int STORE_SIZE  = CONTACTS_PER_MODULE * MAX_MODULES,
    parameter int BCW         = $clog2(STORE_SIZE + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                start_req,
    input  logic                data_pin,
    input  logic [UNIT_W-1:0]   unit_ticks,
    input  logic [MODCNT_W-1:0] module_count,
    output seq_ctrl_t           ctrl,
    output line_set_t           lines_next,
    output logic [BCW-1:0]      bit_cnt,
    output logic [BCW-1:0]      fill_next,
    output logic [BCW-1:0]      total_bits
);

    // Phase codes
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_LOAD_A = 4'd1;
    localparam logic [3:0] PH_LOAD_B = 4'd2;
    localparam logic [3:0] PH_CLKH_A = 4'd3;
    localparam logic [3:0] PH_CLKH_B = 4'd4;
    localparam logic [3:0] PH_CLKL_A = 4'd5;
    localparam logic [3:0] PH_CLKL_B = 4'd6;
    localparam logic [3:0] PH_RSTH_A = 4'd7;
    localparam logic [3:0] PH_RSTH_B = 4'd8;
    localparam logic [3:0] PH_RSTL_A = 4'd9;
    localparam logic [3:0] PH_RSTL_B = 4'd10;
    localparam logic [3:0] PH_PRE    = 4'd11;
    localparam logic [3:0] PH_POST   = 4'd12;
    localparam logic [3:0] PH_BCLK_A = 4'd13;
    localparam logic [3:0] PH_BCLK_B = 4'd14;
    localparam logic [3:0] PH_BPRE   = 4'd15;

    localparam int CPM_SHIFT = $clog2(CONTACTS_PER_MODULE);

    logic [3:0]        phase_reg, phase_next;
    logic [UNIT_W-1:0] unit_cnt_reg, unit_cnt_next;
    logic [BCW-1:0]    bit_cnt_reg, bit_cnt_next;
    line_set_t         lines_reg;
    line_set_t         lines_nx;

    logic [UNIT_W:0]   units;
    logic [UNIT_W:0]   unit_inc;
    logic [BCW-1:0]    mc_ext;
    logic [BCW-1:0]    mc_clamp;
    logic [BCW-1:0]    total;
    logic [BCW-1:0]    bit_inc;
    seq_ctrl_t         ctrl_c;

    // Clamp module count and a zero unit length
    always_comb
    begin
        mc_ext = BCW'(module_count);
        if (mc_ext == '0)
            mc_clamp = BCW'(1);
        else if (mc_ext > BCW'(MAX_MODULES))
            mc_clamp = BCW'(MAX_MODULES);
        else
            mc_clamp = mc_ext;
        total = mc_clamp << CPM_SHIFT;
        units = (unit_ticks == '0) ? (UNIT_W+1)'(1) : {1'b0, unit_ticks};
    end

    // Next state of the sequencer for this tick
    always_comb
    begin
        phase_next    = phase_reg;
        unit_cnt_next = unit_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        lines_nx      = lines_reg;
        ctrl_c        = '0;
        ctrl_c.wr_bit = data_pin;
        unit_inc      = {1'b0, unit_cnt_reg} + (UNIT_W+1)'(1);
        bit_inc       = bit_cnt_reg + BCW'(1);

        if (adv)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (start_req)
                begin
                    lines_nx      = '{load_l: 1'b1, clock_l: 1'b0, reset_l: 1'b0};
                    phase_next    = PH_LOAD_A;
                    unit_cnt_next = '0;
                    bit_cnt_next  = '0;
                    ctrl_c.busy   = 1'b1;
                end
            end
            else
            begin
                ctrl_c.busy = 1'b1;
                if (unit_inc >= units)
                begin
                    unit_cnt_next = '0;
                    unique case (phase_reg)
                        PH_LOAD_A, PH_CLKH_A, PH_CLKL_A,
                        PH_RSTH_A, PH_RSTL_A, PH_BCLK_A:
                        begin
                            phase_next = phase_reg + 4'd1;
                        end
                        PH_LOAD_B:
                        begin
                            lines_nx.clock_l = 1'b1;
                            phase_next       = PH_CLKH_A;
                        end
                        PH_CLKH_B:
                        begin
                            lines_nx.clock_l = 1'b0;
                            phase_next       = PH_CLKL_A;
                        end
                        PH_CLKL_B:
                        begin
                            lines_nx.reset_l = 1'b1;
                            phase_next       = PH_RSTH_A;
                        end
                        PH_RSTH_B:
                        begin
                            lines_nx.reset_l = 1'b0;
                            phase_next       = PH_RSTL_A;
                        end
                        PH_RSTL_B:
                        begin
                            lines_nx.load_l = 1'b0;
                            phase_next      = PH_PRE;
                        end
                        PH_PRE, PH_BPRE:
                        begin
                            // Sample one data bit into the store
                            if (bit_cnt_reg < total)
                            begin
                                ctrl_c.wr_en = 1'b1;
                                bit_cnt_next = bit_inc;
                                ctrl_c.done  = (bit_inc >= total);
                            end
                            phase_next = PH_POST;
                        end
                        PH_POST:
                        begin
                            if (bit_cnt_reg >= total)
                                phase_next = PH_IDLE;
                            else
                            begin
                                lines_nx.clock_l = 1'b1;
                                phase_next       = PH_BCLK_A;
                            end
                        end
                        PH_BCLK_B:
                        begin
                            lines_nx.clock_l = 1'b0;
                            phase_next       = PH_BPRE;
                        end
                        PH_IDLE:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                else
                    unit_cnt_next = unit_inc[UNIT_W-1:0];
            end
        end
    end

    // Hold or advance sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            unit_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            lines_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            unit_cnt_reg <= unit_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            lines_reg    <= lines_nx;
        end
    end

    assign ctrl       = ctrl_c;
    assign lines_next = lines_nx;
    assign bit_cnt    = bit_cnt_reg;
    assign fill_next  = bit_cnt_next;
    assign total_bits = total;

    // All lines rest low while idle
    a_idle_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> lines_reg == '0)
        else $error("bus line high while sequencer idle");

    // Clock and reset never pulse together
    a_clk_rst_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(lines_reg.clock_l && lines_reg.reset_l))
        else $error("clock and reset lines high together");

    // A store write only happens in a sample phase and bumps the fill count
    a_write_bumps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_c.wr_en |-> (phase_reg == PH_PRE || phase_reg == PH_BPRE)
                         && bit_cnt_next == bit_inc)
        else $error("store write outside a sample phase");

endmodule

// ===== hw/rtl/s88fb_store.sv =====
// Contact store of the s88 feedback bus reader with query read port.
// Entries at or above the fill count read as zero; same-tick writes are bypassed.
// Depends on s88fb_pkg.
`timescale 1ns / 1ps

module s88fb_store
    import s88fb_pkg::*;
#(
    parameter int STORE_SIZE = CONTACTS_PER_MODULE * DEF_MAX_MODULES,
    parameter int BCW        = $clog2(STORE_SIZE + 1),
    parameter int AW         = $clog2(STORE_SIZE)
)
(
    input  logic               clk,
    input  logic               adv,
    input  seq_ctrl_t          ctrl,
    input  logic [BCW-1:0]     bit_cnt,
    input  logic [BCW-1:0]     fill_next,
    input  logic [BCW-1:0]     total_bits,
    input  logic [QUERY_W-1:0] query_index,
    output logic               contact_state,
    output logic               query_valid
);

    localparam int QBW = (BCW > QUERY_W) ? BCW : QUERY_W;

    logic mem [STORE_SIZE];

    logic [QBW-1:0] q_ext;
    logic [QBW-1:0] q_m1;
    logic [AW-1:0]  rd_addr;
    logic           q_ok;
    logic           in_fill;
    logic           hit;

    logic rd_reg;
    logic hit_reg;
    logic byp_reg;
    logic fill_reg;
    logic qv_reg;

    // Decode the query against the fill count and the bus length
    always_comb
    begin
        q_ext   = QBW'(query_index);
        q_m1    = q_ext - QBW'(1);
        rd_addr = q_m1[AW-1:0];
        q_ok    = (query_index != '0) && (q_ext <= QBW'(total_bits));
        in_fill = q_m1 < QBW'(fill_next);
        hit     = ctrl.wr_en && (QBW'(bit_cnt) == q_m1);
    end

    // Write sampled bit, read queried contact
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[bit_cnt[AW-1:0]] <= ctrl.wr_bit;
        if (adv)
        begin
            rd_reg   <= mem[rd_addr];
            hit_reg  <= hit;
            byp_reg  <= ctrl.wr_bit;
            fill_reg <= in_fill;
            qv_reg   <= q_ok;
        end
    end

    assign contact_state = qv_reg && fill_reg && (hit_reg ? byp_reg : rd_reg);
    assign query_valid   = qv_reg;

endmodule

// ===== hw/rtl/s88_feedback_bus_reader.sv =====
// s88 feedback bus reader: an input word passes the input register, then the result register,
// to the result word; one word accepted per cycle while the input does not stall.
// The result register frees when its word is taken, so input stalls only when both hold and the output stalls.
// Reset: sequencer idle, all bus lines low, unit_ticks 25, module_count 1;
// the contact store reads zero through its fill count, with no clearing pass.
// Depends on s88fb_pkg, s88fb_seq and s88fb_store.
`timescale 1ns / 1ps

module s88_feedback_bus_reader
    import s88fb_pkg::*;
#(
    parameter int MAX_MODULES = DEF_MAX_MODULES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_SIZE = CONTACTS_PER_MODULE * MAX_MODULES;
    localparam int BCW        = $clog2(STORE_SIZE + 1);
    localparam int AW         = $clog2(STORE_SIZE);

    logic [UNIT_W-1:0]   unit_ticks_reg;
    logic [MODCNT_W-1:0] module_count_reg;

    in_word_t  in_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    line_set_t lines_out_reg;
    logic      busy_reg;
    logic      done_reg;

    logic           adv;
    seq_ctrl_t      ctrl;
    line_set_t      lines_next;
    logic [BCW-1:0] bit_cnt;
    logic [BCW-1:0] fill_next;
    logic [BCW-1:0] total_bits;
    logic           contact_state;
    logic           query_valid;

    // Move the held word into the result stage when that stage frees
    assign adv      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg   <= UNIT_TICKS_RESET;
            module_count_reg <= MODULE_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_UNIT_TICKS:   unit_ticks_reg   <= cfg_data[UNIT_W-1:0];
                REG_MODULE_COUNT: module_count_reg <= cfg_data[MODCNT_W-1:0];
            endcase
        end
    end

    // Input and result stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Input word and result payload
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_reg <= in_word;
        if (adv)
        begin
            lines_out_reg <= lines_next;
            busy_reg      <= ctrl.busy;
            done_reg      <= ctrl.done;
        end
    end

    s88fb_seq #(
        .MAX_MODULES (MAX_MODULES),
        .STORE_SIZE  (STORE_SIZE),
        .BCW         (BCW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .start_req    (in_reg.start_req),
        .data_pin     (in_reg.data_pin),
        .unit_ticks   (unit_ticks_reg),
        .module_count (module_count_reg),
        .ctrl         (ctrl),
        .lines_next   (lines_next),
        .bit_cnt      (bit_cnt),
        .fill_next    (fill_next),
        .total_bits   (total_bits)
    );

    s88fb_store #(
        .STORE_SIZE (STORE_SIZE),
        .BCW        (BCW),
        .AW         (AW)
    ) u_store (
        .clk           (clk),
        .adv           (adv),
        .ctrl          (ctrl),
        .bit_cnt       (bit_cnt),
        .fill_next     (fill_next),
        .total_bits    (total_bits),
        .query_index   (in_reg.query_index),
        .contact_state (contact_state),
        .query_valid   (query_valid)
    );

    // Drive the result word
    assign out_valid              = out_valid_reg;
    assign out_word.load_line     = lines_out_reg.load_l;
    assign out_word.clock_line    = lines_out_reg.clock_l;
    assign out_word.reset_line    = lines_out_reg.reset_l;
    assign out_word.busy_res      = busy_reg;
    assign out_word.done_res      = done_reg;
    assign out_word.contact_state = contact_state;
    assign out_word.query_valid   = query_valid;

    // Done only shows during a refresh
    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> busy_reg)
        else $error("done raised outside a refresh");

    // An invalid query never reports a set contact
    a_invalid_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !query_valid |-> !contact_state)
        else $error("contact set on invalid query");

endmodule
